// ----- hw/rtl/rmsd_pkg.sv -----
// rmsd_pkg: types and constants for the run mean / standard deviation meter
// no dependencies; imported by every module of the block
`default_nettype none

package rmsd_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 32;
    localparam int SPR_W      = 21;
    localparam int RLIM_W     = 16;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 1;
    localparam int M2_W       = 64;

    // sequencer step counts and the remainder width the root needs
    localparam int ITER_W         = 7;
    localparam int MEAN_DIV_STEPS = 32;
    localparam int VAR_DIV_STEPS  = 64;
    localparam int SQRT_STEPS     = 32;
    localparam int SQRT_REM_W     = 35;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_RUN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT       = 1'b1;

    // input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_START  = 1'b1;

    typedef struct packed {
        logic                       opcode;
        logic signed [SAMPLE_W-1:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] run_mean;
        logic [SAMPLE_W-1:0]        run_stddev;
        logic [RLIM_W-1:0]          run_index;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MEAN,
        ST_RESID,
        ST_MUL,
        ST_M2,
        ST_VDIV,
        ST_SQRT,
        ST_DONE
    } seq_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rmsd_csu.sv -----
// rmsd_csu: shared compare-and-subtract unit for the divider and root steps
// depends on rmsd_pkg
`default_nettype none

module rmsd_csu
    import rmsd_pkg::*;
#(
    parameter int W = 35
)
(
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              ge,
    output logic [W-1:0]      diff
);

    logic [W:0] wide_diff;

    always_comb
    begin
        wide_diff = {1'b0, a} - {1'b0, b};
        ge        = ~wide_diff[W];
        diff      = wide_diff[W-1:0];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/run_mean_stddev_meter.sv -----
// run_mean_stddev_meter: running mean and sample standard deviation per run
// start and ignored requests are handled in idle; a sample runs a 32-step mean division
// a run's last sample, from two samples up, adds a 64-step M2 division and 32-step root
// one request at a time; the division and root steps share one compare-subtract unit
// reset: run length 1024, run limit 16, disarmed, counts, mean and M2 cleared
// depends on rmsd_pkg and rmsd_csu
`default_nettype none

module run_mean_stddev_meter
    import rmsd_pkg::*;
#(
    parameter int COUNT_WIDTH = 21
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int UW = (COUNT_WIDTH + 1 > SQRT_REM_W) ? COUNT_WIDTH + 1 : SQRT_REM_W;

    seq_state_t state_reg, state_next;

    logic [SPR_W-1:0]         spr_reg;
    logic [RLIM_W-1:0]        rlim_reg;
    logic                     armed_reg;
    logic [COUNT_WIDTH-1:0]   count_reg;
    logic [RLIM_W-1:0]        runs_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic [M2_W-1:0]          m2_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic                     delta_neg_reg;
    logic [SAMPLE_W-1:0]      delta_mag_reg;
    logic                     resid_neg_reg;
    logic [SAMPLE_W-1:0]      resid_mag_reg;
    logic [M2_W-1:0]          prod_reg;
    logic [M2_W-1:0]          qq_reg;
    logic [UW-1:0]            rem_reg;
    logic [COUNT_WIDTH-1:0]   div_reg;
    logic [SAMPLE_W-1:0]      root_reg;
    logic [ITER_W-1:0]        iter_reg;

    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    logic                   accept;
    logic                   go;
    logic                   step_last;
    logic                   run_end;
    logic                   out_load;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] target;
    logic [SPR_W+COUNT_WIDTH-1:0] spr_ext;
    logic [UW-1:0]          unit_a;
    logic [UW-1:0]          unit_b;
    logic                   unit_ge;
    logic [UW-1:0]          unit_diff;

    logic signed [SAMPLE_W:0]   delta_full;
    logic [SAMPLE_W:0]          delta_abs;
    logic signed [SAMPLE_W:0]   resid_full;
    logic [SAMPLE_W:0]          resid_abs;
    logic signed [SAMPLE_W+1:0] step_val;
    logic signed [SAMPLE_W+1:0] mean_sum;
    logic [M2_W:0]              m2_sum;
    logic [M2_W:0]              m2_sub;
    logic [M2_W-1:0]            m2_next;

    rmsd_csu #(
        .W (UW)
    ) u_csu (
        .a    (unit_a),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    // shared datapath arithmetic
    always_comb
    begin
        count_next = count_reg + COUNT_WIDTH'(1);
        spr_ext    = {{COUNT_WIDTH{1'b0}}, spr_reg};
        target     = spr_ext[COUNT_WIDTH-1:0];
        run_end    = (count_reg >= target);

        delta_full = {in_data.sample_value[SAMPLE_W-1], in_data.sample_value}
                     - {mean_reg[SAMPLE_W-1], mean_reg};
        delta_abs  = delta_full[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - delta_full) : delta_full;

        step_val   = delta_neg_reg ? ((SAMPLE_W+2)'(0) - {2'b00, qq_reg[SAMPLE_W-1:0]})
                                   : {2'b00, qq_reg[SAMPLE_W-1:0]};
        mean_sum   = {{2{mean_reg[SAMPLE_W-1]}}, mean_reg} + step_val;

        resid_full = {x_reg[SAMPLE_W-1], x_reg} - {mean_reg[SAMPLE_W-1], mean_reg};
        resid_abs  = resid_full[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - resid_full) : resid_full;

        // same signs add with saturation, opposite signs subtract and clamp at zero
        m2_sum = {1'b0, m2_reg} + {1'b0, prod_reg};
        m2_sub = {1'b0, m2_reg} - {1'b0, prod_reg};
        if (delta_neg_reg == resid_neg_reg)
        begin
            m2_next = m2_sum[M2_W] ? {M2_W{1'b1}} : m2_sum[M2_W-1:0];
        end
        else
        begin
            m2_next = m2_sub[M2_W] ? {M2_W{1'b0}} : m2_sub[M2_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_last)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:  state_next = ST_RESID;
            ST_RESID: state_next = ST_MUL;
            ST_MUL:   state_next = ST_M2;
            ST_M2:
            begin
                if (!run_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (count_reg >= COUNT_WIDTH'(2))
                begin
                    state_next = ST_VDIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_VDIV:
            begin
                if (step_last)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (step_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and shared unit operand selection
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        accept    = in_valid && in_ready;
        go        = accept && (in_data.opcode == OP_SAMPLE) && armed_reg
                    && (runs_reg < rlim_reg);
        step_last = (iter_reg == ITER_W'(1));
        out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
        unique case (state_reg)
            ST_SQRT:
            begin
                unit_a = {rem_reg[UW-3:0], qq_reg[M2_W-1 -: 2]};
                unit_b = {{(UW-SAMPLE_W-2){1'b0}}, root_reg, 2'b01};
            end
            default:
            begin
                unit_a = {rem_reg[UW-2:0], qq_reg[M2_W-1]};
                unit_b = {{(UW-COUNT_WIDTH){1'b0}}, div_reg};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg  <= SPR_W'(1024);
            rlim_reg <= RLIM_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLES_PER_RUN: spr_reg  <= cfg_data[SPR_W-1:0];
                REG_RUN_LIMIT:       rlim_reg <= cfg_data[RLIM_W-1:0];
                default:             ;
            endcase
        end
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            count_reg <= '0;
            runs_reg  <= '0;
            mean_reg  <= '0;
            m2_reg    <= '0;
        end
        else
        begin
            if (accept && (in_data.opcode == OP_START))
            begin
                armed_reg <= 1'b1;
            end
            if (go)
            begin
                count_reg <= count_next;
            end
            // a wrapped count of zero leaves the mean alone
            if (state_reg == ST_MEAN && count_reg != '0)
            begin
                mean_reg <= mean_sum[SAMPLE_W-1:0];
            end
            if (state_reg == ST_M2)
            begin
                m2_reg <= m2_next;
            end
            if (out_load)
            begin
                runs_reg  <= runs_reg + RLIM_W'(1);
                armed_reg <= 1'b0;
                count_reg <= '0;
                mean_reg  <= '0;
                m2_reg    <= '0;
            end
        end
    end

    // working registers of the sequencer
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    x_reg         <= in_data.sample_value;
                    delta_neg_reg <= delta_full[SAMPLE_W];
                    delta_mag_reg <= delta_abs[SAMPLE_W-1:0];
                    qq_reg        <= {delta_abs[SAMPLE_W-1:0], {(M2_W-SAMPLE_W){1'b0}}};
                    rem_reg       <= '0;
                    div_reg       <= count_next;
                    iter_reg      <= ITER_W'(MEAN_DIV_STEPS);
                end
            end
            ST_DIV, ST_VDIV:
            begin
                qq_reg <= {qq_reg[M2_W-2:0], unit_ge};
                if (state_reg == ST_VDIV && step_last)
                begin
                    rem_reg  <= '0;
                    root_reg <= '0;
                    iter_reg <= ITER_W'(SQRT_STEPS);
                end
                else
                begin
                    rem_reg  <= unit_ge ? unit_diff : unit_a;
                    iter_reg <= iter_reg - ITER_W'(1);
                end
            end
            ST_RESID:
            begin
                resid_neg_reg <= resid_full[SAMPLE_W];
                resid_mag_reg <= resid_abs[SAMPLE_W-1:0];
            end
            ST_MUL:
            begin
                prod_reg <= M2_W'(delta_mag_reg) * M2_W'(resid_mag_reg);
            end
            ST_M2:
            begin
                qq_reg   <= m2_next;
                rem_reg  <= '0;
                div_reg  <= count_reg - COUNT_WIDTH'(1);
                iter_reg <= ITER_W'(VAR_DIV_STEPS);
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                qq_reg   <= {qq_reg[M2_W-3:0], 2'b00};
                rem_reg  <= unit_ge ? unit_diff : unit_a;
                root_reg <= {root_reg[SAMPLE_W-2:0], unit_ge};
                iter_reg <= iter_reg - ITER_W'(1);
            end
            default: ;
        endcase
    end

    // output register, free to take the next result once this one is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.run_mean   <= mean_reg;
            out_data_reg.run_stddev <= root_reg;
            out_data_reg.run_index  <= runs_reg + RLIM_W'(1);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
